// ----- rtl/core/dart_pkg.sv -----
package dart_pkg;

    // divider period and the phase widths that follow from it
    localparam int DIV_PERIOD  = 256;
    localparam int DIV_PHASE_W = (DIV_PERIOD > 2) ? $clog2(DIV_PERIOD) : 1;
    localparam int DIV_SUM_W   = ((DIV_PHASE_W > 8) ? DIV_PHASE_W : 8) + 1;

    // accumulator phase is 10 bits, sum with an 8-bit tick needs 11
    localparam int ACC_PHASE_W = 10;
    localparam int ACC_SUM_W   = ACC_PHASE_W + 1;

    // register map
    localparam logic [15:0] ADDR_DIV = 16'hff04;
    localparam logic [15:0] ADDR_ACC = 16'hff05;
    localparam logic [15:0] ADDR_RLD = 16'hff06;
    localparam logic [15:0] ADDR_CTL = 16'hff07;

    localparam logic [7:0] ACC_MAX = 8'hff;

    // request kinds
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

    // one input request
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  cycles;
        logic [15:0] bus_addr;
        logic [7:0]  write_data;
    } t_req;

    // one result
    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic       addr_error;
    } t_result;

    // accumulator phase limit for each rate code
    function automatic logic [ACC_SUM_W-1:0] rate_limit(input logic [1:0] rate);
        logic [ACC_SUM_W-1:0] lim;
        case (rate)
            2'd0:    lim = ACC_SUM_W'(1024);
            2'd1:    lim = ACC_SUM_W'(16);
            2'd2:    lim = ACC_SUM_W'(64);
            default: lim = ACC_SUM_W'(256);
        endcase
        return lim;
    endfunction

endpackage

// ----- rtl/core/dart_in_reg.sv -----
module dart_in_reg
    import dart_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_take,
    output t_req o_req
);

    logic r_valid;
    t_req r_req;

    // free when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ----- rtl/core/dart_core.sv -----
module dart_core
    import dart_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_req    i_req,
    output t_result o_result
);

    logic [7:0]             r_div_count, n_div_count;
    logic [DIV_PHASE_W-1:0] r_div_phase, n_div_phase;
    logic [7:0]             r_accumulator, n_accumulator;
    logic [7:0]             r_reload, n_reload;
    logic [2:0]             r_control, n_control;
    logic [ACC_PHASE_W-1:0] r_acc_phase, n_acc_phase;

    logic [DIV_SUM_W-1:0] div_sum;
    logic [ACC_SUM_W-1:0] acc_sum;
    t_result              res;

    // phase sums for a tick
    assign div_sum = DIV_SUM_W'(r_div_phase) + DIV_SUM_W'(i_req.cycles);
    assign acc_sum = ACC_SUM_W'(r_acc_phase) + ACC_SUM_W'(i_req.cycles);

    // next state and result
    always_comb begin
        n_div_count   = r_div_count;
        n_div_phase   = r_div_phase;
        n_accumulator = r_accumulator;
        n_reload      = r_reload;
        n_control     = r_control;
        n_acc_phase   = r_acc_phase;
        res           = '0;
        case (i_req.mode)
            MODE_TICK: begin
                if (div_sum >= DIV_SUM_W'(DIV_PERIOD)) begin
                    n_div_phase = '0;
                    n_div_count = r_div_count + 8'd1;
                end else begin
                    n_div_phase = div_sum[DIV_PHASE_W-1:0];
                end
                if (r_control[2]) begin
                    if (acc_sum >= rate_limit(r_control[1:0])) begin
                        n_acc_phase = '0;
                        if (r_accumulator == ACC_MAX) begin
                            n_accumulator = r_reload;
                            res.timer_irq = 1'b1;
                        end else begin
                            n_accumulator = r_accumulator + 8'd1;
                        end
                    end else begin
                        n_acc_phase = acc_sum[ACC_PHASE_W-1:0];
                    end
                end
            end
            MODE_READ: begin
                unique case (i_req.bus_addr)
                    ADDR_DIV: res.read_data = r_div_count;
                    ADDR_ACC: res.read_data = r_accumulator;
                    ADDR_RLD: res.read_data = r_reload;
                    ADDR_CTL: res.read_data = {5'd0, r_control};
                    default:  res.addr_error = 1'b1;
                endcase
            end
            MODE_WRITE: begin
                unique case (i_req.bus_addr)
                    ADDR_DIV: begin
                        n_div_count = '0;
                        n_div_phase = '0;
                    end
                    ADDR_ACC: n_accumulator = i_req.write_data;
                    ADDR_RLD: n_reload = i_req.write_data;
                    ADDR_CTL: begin
                        if (r_control[1:0] != i_req.write_data[1:0]) begin
                            n_acc_phase = '0;
                        end
                        n_control = i_req.write_data[2:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_count   <= '0;
            r_div_phase   <= '0;
            r_accumulator <= '0;
            r_reload      <= '0;
            r_control     <= '0;
            r_acc_phase   <= '0;
        end else if (i_fire) begin
            r_div_count   <= n_div_count;
            r_div_phase   <= n_div_phase;
            r_accumulator <= n_accumulator;
            r_reload      <= n_reload;
            r_control     <= n_control;
            r_acc_phase   <= n_acc_phase;
        end
    end

    assign o_result = res;

    // divider write clears the divider
    a_div_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.mode == MODE_WRITE && i_req.bus_addr == ADDR_DIV)
        |=> (r_div_count == 8'd0))
        else $error("divider not cleared after write");

    // interrupt only from an enabled, full accumulator
    a_irq_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.timer_irq) |-> (r_control[2] && r_accumulator == ACC_MAX))
        else $error("interrupt without accumulator overflow");

    // phase stays below the current limit
    a_phase_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ACC_SUM_W'(r_acc_phase) < rate_limit(r_control[1:0]))
        else $error("accumulator phase at or above limit");

    // an error read returns zero data
    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.addr_error |-> (res.read_data == 8'd0 && !res.timer_irq))
        else $error("error read with nonzero result");

endmodule

// ----- rtl/core/dart_out_reg.sv -----
module dart_out_reg
    import dart_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    output logic    o_free,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // can take a new result when empty or when the held one leaves
    assign o_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/core/divider_and_reload_timer.sv -----
// Divider and reload timer: each request is a tick with a count of 0 to 255, a register read or a
// register write at 0xff04 (divider), 0xff05 (accumulator), 0xff06 (reload) or 0xff07
// (control), and gives exactly one result. Requests pass through an input register, are
// worked combinationally against the timer state, and land in an output register, so a new
// request can be taken every cycle; a request is held in the input register and its result
// then in the output register, where it becomes valid. Throughput drops only while the output
// register is held by a stalled consumer.
module divider_and_reload_timer
    import dart_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_cycles,
    input  logic [15:0] i_bus_addr,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_timer_irq,
    output logic        o_addr_error
);

    t_req    in_req;
    t_req    held_req;
    t_result core_result;
    t_result out_result;
    logic    held_valid;
    logic    out_free;
    logic    fire;

    assign in_req = '{mode: i_mode, cycles: i_cycles, bus_addr: i_bus_addr,
                      write_data: i_write_data};

    // request advances when the output register has room
    assign fire = held_valid && out_free;

    // input register
    dart_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (in_req),
        .o_valid (held_valid),
        .i_take  (fire),
        .o_req   (held_req)
    );

    // timer state and request decode
    dart_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (held_req),
        .o_result (core_result)
    );

    // result register
    dart_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .o_free   (out_free),
        .i_result (core_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_read_data  = out_result.read_data;
    assign o_timer_irq  = out_result.timer_irq;
    assign o_addr_error = out_result.addr_error;

endmodule
